// ----- hw/rtl/kst_pkg.sv -----
// package for the keyed stock table: sizes, command and status codes, shared types
`default_nettype none

package kst_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned KEY_BITS    = 8;
  localparam int unsigned SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IKEY_W = 8;
  localparam int unsigned QTY_W  = 32;
  localparam int unsigned STAT_W = 2;

  localparam logic signed [QTY_W-1:0] QTY_MAX = {1'b0, {(QTY_W-1){1'b1}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_ACCUM  = 3'd1,
    CMD_SET    = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_e;

  // search token walking down the chain of cells
  typedef struct packed {
    logic                    active;
    logic                    found;
    logic [SLOT_W-1:0]       slot;
    logic signed [QTY_W-1:0] qty;
  } tok_t;

  // request fields broadcast to every cell
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [KEY_BITS-1:0]     key;
    logic signed [QTY_W-1:0] amount;
    logic [CNT_W-1:0]        count;
    logic                    append_en;
  } bcast_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kst_cell.sv -----
// one table entry: stores key and quantity, checks and updates on the passing token
`default_nettype none

module kst_cell import kst_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SLOT_W-1:0] idx_i,
  input  wire bcast_t            bc_i,
  input  wire tok_t              tok_i,
  output tok_t                   tok_o
);

  logic [KEY_BITS-1:0]     key_q, key_d;
  logic signed [QTY_W-1:0] qty_q, qty_d;
  tok_t                    tok_q, tok_d;

  logic                    in_use;
  logic                    hit;
  logic signed [QTY_W:0]   sum;
  logic signed [QTY_W-1:0] new_qty;

  // saturating add of the delta, then clamp below at zero
  assign sum = {qty_q[QTY_W-1], qty_q} + {bc_i.amount[QTY_W-1], bc_i.amount};

  assign in_use = {{(CNT_W-SLOT_W){1'b0}}, idx_i} < bc_i.count;
  assign hit    = tok_i.active && !tok_i.found && in_use && (key_q == bc_i.key);

  // new quantity for a matching entry
  always_comb begin
    case (bc_i.cmd)
      CMD_ACCUM: begin
        if (sum[QTY_W]) begin
          new_qty = '0;
        end else if (sum[QTY_W-1]) begin
          new_qty = QTY_MAX;
        end else begin
          new_qty = sum[QTY_W-1:0];
        end
      end
      CMD_SET:  new_qty = bc_i.amount[QTY_W-1] ? '0 : bc_i.amount;
      default:  new_qty = qty_q;
    endcase
  end

  // entry write on append or on a match, token hand-off
  always_comb begin
    key_d = key_q;
    qty_d = qty_q;
    tok_d = tok_i;
    if (bc_i.append_en && (idx_i == bc_i.count[SLOT_W-1:0])) begin
      key_d = bc_i.key;
      qty_d = bc_i.amount;
    end
    if (hit) begin
      qty_d       = new_qty;
      tok_d.found = 1'b1;
      tok_d.slot  = idx_i;
      tok_d.qty   = new_qty;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    qty_q <= qty_d;
  end

  // token register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_stock_table_top.sv -----
// keyed stock table: controller, chain of entry cells and result register
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | cmd_i, item_key_i, amount_i
//   out     | output    | out_valid_o / out_stall_i| quantity_o, found_o, slot_o,
//           |           |                         | entries_used_o, status_o
//
// accumulate, set and lookup search the chain:
//   a search token walks the chain one cell per cycle, then the result is staged and registered
// append, clear and unused codes skip the chain; one request is in flight at a time
// reset empties the table at once; entry contents are not cleared
// a stalled result holds in the output register; the next request is taken meanwhile
`default_nettype none

module keyed_stock_table_top import kst_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [CMD_W-1:0]        cmd_i,
  input  wire logic [IKEY_W-1:0]       item_key_i,
  input  wire logic signed [QTY_W-1:0] amount_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [QTY_W-1:0]      quantity_o,
  output logic                         found_o,
  output logic [SLOT_W-1:0]            slot_o,
  output logic [CNT_W-1:0]             entries_used_o,
  output logic [STAT_W-1:0]            status_o
);

  typedef struct packed {
    logic signed [QTY_W-1:0] qty;
    logic                    found;
    logic [SLOT_W-1:0]       slot;
    logic [CNT_W-1:0]        used;
    logic [STAT_W-1:0]       status;
  } res_t;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic signed [QTY_W-1:0] amount_q, amount_d;
  res_t               pend_q, pend_d;
  res_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               accept;
  logic               out_free;
  logic               append_en;
  bcast_t             bc;
  tok_t               tok [TABLE_DEPTH+1];

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // requests flow straight to the cells in the accept cycle, held ones afterwards
  always_comb begin
    bc.cmd       = accept ? cmd_i : cmd_q;
    bc.key       = accept ? item_key_i[KEY_BITS-1:0] : key_q;
    bc.amount    = accept ? amount_i : amount_q;
    bc.count     = count_q;
    bc.append_en = append_en;
  end

  // controller: next state, table count, pending result and token launch
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    amount_d  = amount_q;
    pend_d    = pend_q;
    append_en = 1'b0;
    tok[0]    = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          key_d    = item_key_i[KEY_BITS-1:0];
          amount_d = amount_i;
          pend_d   = '0;
          pend_d.used = count_q;
          state_d  = S_FINISH;
          case (cmd_i)
            CMD_APPEND: begin
              if (count_q >= CNT_W'(TABLE_DEPTH)) begin
                pend_d.status = ST_FULL;
              end else begin
                append_en   = 1'b1;
                count_d     = count_q + 1'b1;
                pend_d.qty  = amount_i;
                pend_d.slot = count_q[SLOT_W-1:0];
                pend_d.used = count_q + 1'b1;
              end
            end
            CMD_ACCUM, CMD_SET, CMD_LOOKUP: begin
              tok[0].active = 1'b1;
              state_d       = S_SEARCH;
            end
            CMD_CLEAR: begin
              count_d     = '0;
              pend_d.used = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        // token leaves the last cell
        if (tok[TABLE_DEPTH].active) begin
          pend_d.found  = tok[TABLE_DEPTH].found;
          pend_d.qty    = tok[TABLE_DEPTH].found ? tok[TABLE_DEPTH].qty : '0;
          pend_d.slot   = tok[TABLE_DEPTH].found ? tok[TABLE_DEPTH].slot : '0;
          pend_d.status = tok[TABLE_DEPTH].found ? ST_OK : ST_NOT_FOUND;
          state_d       = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == S_FINISH && out_free) begin
      out_d       = pend_q;
      out_valid_d = 1'b1;
    end
  end

  // chain of entry cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    kst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_W'(g)),
      .bc_i   (bc),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    amount_q <= amount_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign quantity_o     = out_q.qty;
  assign found_o        = out_q.found;
  assign slot_o         = out_q.slot;
  assign entries_used_o = out_q.used;
  assign status_o       = out_q.status;

  // a token only enters the chain when a search starts
  a_tok_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[1].active |-> state_q == S_SEARCH)
    else $error("search token in chain outside a search");

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // a found entry always reports ok
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK)
    else $error("found result with error status");

  // a search finishes exactly when the token leaves the chain
  a_search_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH && tok[TABLE_DEPTH].active |=> state_q == S_FINISH)
    else $error("search did not finish on token exit");

endmodule

`default_nettype wire
